// ===== hdl/swp_pkg.sv =====
// Shared types, constants and codes for the sliding window percentile filter.
package swp_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int PTR_W        = $clog2(WINDOW_MAX);
  localparam int FILL_W       = 7;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int PERCENT_FULL = 100;

  // rank = (p*n + 99) / 100, the divide done as a multiply by a reciprocal
  localparam int PROD_W       = $clog2(PERCENT_FULL * WINDOW_MAX + PERCENT_FULL);
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP_W      = 18;
  localparam int RECIP_100    = (1 << RECIP_SHIFT) / PERCENT_FULL + 1;

  localparam int GROUP_SIZE   = 8;
  localparam int NUM_GROUPS   = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [FILL_W-1:0]          fill_t;
  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam cfg_idx_t REG_WINDOW_LENGTH = 2'd0;
  localparam cfg_idx_t REG_PERCENT       = 2'd1;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_REMOVE = 2'd1,
    CELL_INSERT = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    sample_t  key;
  } cell_cmd_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHECK  = 8'b0000_0010,
    ST_EVICT  = 8'b0000_0100,
    ST_INSERT = 8'b0000_1000,
    ST_MUL    = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_SEL    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

endpackage

// ===== hdl/swp_if.sv =====
// Valid/ready channel interfaces for samples in and ranked results out.
interface swp_in_if;
  import swp_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    start_req;
  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swp_out_if;
  import swp_pkg::*;
  logic    valid;
  logic    ready;
  sample_t rank_value;
  fill_t   fill_count;
  modport source (output valid, output rank_value, output fill_count, input ready);
  modport sink   (input valid, input rank_value, input fill_count, output ready);
endinterface

// ===== hdl/swp_cell.sv =====
// One cell of the sorted chain: holds one value, shifts left on removal, right on insert.
module swp_cell (
  input  logic               clk,
  input  swp_pkg::cell_cmd_t cmd,
  input  logic               in_range,
  input  logic               sel,
  input  swp_pkg::sample_t   left_val,
  input  logic               left_gt,
  input  swp_pkg::sample_t   right_val,
  output swp_pkg::sample_t   val,
  output logic               gt,
  output swp_pkg::sample_t   sel_val
);
  import swp_pkg::*;

  sample_t val_r;
  sample_t val_nxt;

  // empty cells act as +infinity so the insert lands at the end of the run
  assign gt      = !in_range || (val_r > cmd.key);
  assign val     = val_r;
  assign sel_val = sel ? val_r : '0;

  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      CELL_REMOVE: begin
        if (in_range && (val_r >= cmd.key)) val_nxt = right_val;
      end
      CELL_INSERT: begin
        if (gt) val_nxt = left_gt ? left_val : cmd.key;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hdl/swp_ring.sv =====
// Arrival-order ring of samples: one write port, one registered read port.
module swp_ring (
  input  logic             clk,
  input  logic             we,
  input  swp_pkg::ptr_t    waddr,
  input  swp_pkg::sample_t wdata,
  input  swp_pkg::ptr_t    raddr,
  output swp_pkg::sample_t rdata
);
  import swp_pkg::*;

  sample_t mem [WINDOW_MAX];
  sample_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sliding_window_percentile.sv =====
// Top level of the sliding window percentile (rank-order) filter.
//
// in_if  : valid/ready channel of signed 16-bit samples plus start_req, which
//          empties the window before its sample is added.
// out_if : valid/ready channel; one result per sample: the k-th smallest
//          sample in the window, k = max(1, ceil(percent*n/100)), and fill n.
// cfg_*  : write-only registers, index 0 window_length (0 acts as 1, above
//          64 saturates), index 1 percent (above 100 saturates). Write only
//          while no sample is in flight.
// Flow   : one sample at a time. After the input transfer the control steps
//          through check, insert, multiply, divide, select and output
//          states; each evicted sample adds a further check and an evict
//          state (ring read, then chain removal). A full window evicts one
//          per sample. The sorted window is a chain of 64 cells that all
//          shift in the same cycle.
// Stall  : the result sits in an output register; the block takes the next
//          sample while it waits and holds that one at the end until the
//          register frees up.
// Reset  : rst_n is synchronous, active low; empties the window and sets
//          window_length to 64 and percent to 50.
module sliding_window_percentile (
  input  logic                clk,
  input  logic                rst_n,
  swp_in_if.sink              in_if,
  swp_out_if.source           out_if,
  input  logic                cfg_we,
  input  swp_pkg::cfg_idx_t   cfg_idx,
  input  swp_pkg::cfg_data_t  cfg_wdata
);
  import swp_pkg::*;

  // configuration
  cfg_data_t win_len_r;
  cfg_data_t percent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= cfg_data_t'(WINDOW_MAX);
      percent_r <= cfg_data_t'(PERCENT_FULL / 2);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW_LENGTH: win_len_r <= cfg_wdata;
        REG_PERCENT:       percent_r <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // clamped settings
  fill_t     len_eff;
  cfg_data_t pct_eff;

  always_comb begin
    if (win_len_r == '0)                 len_eff = fill_t'(1);
    else if (int'(win_len_r) > WINDOW_MAX) len_eff = fill_t'(WINDOW_MAX);
    else                                 len_eff = fill_t'(win_len_r);
    pct_eff = (int'(percent_r) > PERCENT_FULL) ? cfg_data_t'(PERCENT_FULL) : percent_r;
  end

  // control state
  state_t  state_r, state_nxt;
  fill_t   fill_r;
  ptr_t    ptr_r;
  sample_t sample_r;
  logic [PROD_W-1:0] prod_r;
  fill_t   k_r;

  logic    in_xfer;
  logic    out_load;
  sample_t ring_rd;
  ptr_t    ring_waddr;

  assign in_if.ready = (state_r == ST_IDLE) && rst_n;
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_load    = (state_r == ST_OUT) && (!out_if.valid || out_if.ready);
  assign ring_waddr  = ptr_r + ptr_t'(fill_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = (fill_r >= len_eff) ? ST_EVICT : ST_INSERT;
      ST_EVICT:  state_nxt = ST_CHECK;
      ST_INSERT: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_SEL;
      ST_SEL:    state_nxt = ST_OUT;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // rank arithmetic: p*n, then (p*n + 99) / 100 via reciprocal
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  assign recip_prod = (PROD_W+RECIP_W)'(prod_r + PROD_W'(PERCENT_FULL - 1))
                    * (PROD_W+RECIP_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer && in_if.start_req) begin
        fill_r <= '0;
        ptr_r  <= '0;
      end else if (state_r == ST_EVICT) begin
        fill_r <= fill_r - fill_t'(1);
        ptr_r  <= ptr_r + ptr_t'(1);
      end else if (state_r == ST_INSERT) begin
        fill_r <= fill_r + fill_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) sample_r <= in_if.sample;
    if (state_r == ST_MUL) prod_r <= PROD_W'(pct_eff) * PROD_W'(fill_r);
    if (state_r == ST_DIV) k_r <= recip_prod[RECIP_SHIFT +: FILL_W];
  end

  // arrival ring; read port always points at the oldest sample
  swp_ring u_ring (
    .clk   (clk),
    .we    (state_r == ST_INSERT),
    .waddr (ring_waddr),
    .wdata (sample_r),
    .raddr (ptr_r),
    .rdata (ring_rd)
  );

  // sorted chain of cells
  cell_cmd_t cmd;
  ptr_t      ksel;
  fill_t     k_eff;

  always_comb begin
    cmd.op  = CELL_HOLD;
    cmd.key = sample_r;
    case (state_r)
      ST_EVICT: begin
        cmd.op  = CELL_REMOVE;
        cmd.key = ring_rd;
      end
      ST_INSERT: cmd.op = CELL_INSERT;
      default:   cmd.op = CELL_HOLD;
    endcase
    k_eff = (k_r == '0) ? fill_t'(1) : k_r;
    ksel  = ptr_t'(k_eff - fill_t'(1));
  end

  sample_t cell_val [WINDOW_MAX];
  logic    cell_gt  [WINDOW_MAX];
  sample_t cell_sel [WINDOW_MAX];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    sample_t left_val;
    logic    left_gt;
    sample_t right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    swp_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .in_range  (fill_t'(i) < fill_r),
      .sel       (ptr_t'(i) == ksel),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .val       (cell_val[i]),
      .gt        (cell_gt[i]),
      .sel_val   (cell_sel[i])
    );
  end

  // two-level OR tree picks the selected cell; group stage is registered
  sample_t grp_r   [NUM_GROUPS];
  sample_t grp_nxt [NUM_GROUPS];
  sample_t pick;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < WINDOW_MAX) grp_nxt[g] = grp_nxt[g] | cell_sel[g * GROUP_SIZE + j];
      end
    end
    pick = '0;
    for (int g = 0; g < NUM_GROUPS; g++) pick = pick | grp_r[g];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SEL) grp_r <= grp_nxt;
  end

  // output register
  logic    out_valid_r;
  sample_t out_rank_r;
  fill_t   out_fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rank_r <= pick;
      out_fill_r <= fill_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.rank_value = out_rank_r;
  assign out_if.fill_count = out_fill_r;

endmodule

// ===== tb/sv/sliding_window_percentile_test.sv =====
// Self-checking testbench for the sliding window percentile filter: directed and random samples.
module sliding_window_percentile_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swp_pkg::*;

  // Register indexes outside the map; writes to them must change nothing
  localparam cfg_idx_t REG_UNMAPPED_LO = 2'd2;
  localparam cfg_idx_t REG_UNMAPPED_HI = 2'd3;

  localparam int RANDOM_TARGET = 1750;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    sample_t sample;
    logic    start_req;
  } sample_item_t;

  typedef struct packed {
    sample_t rank_value;
    fill_t   fill_count;
  } rank_result_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_wdata;

  swp_in_if  in_ch ();
  swp_out_if out_ch ();

  sliding_window_percentile DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Samples waiting for the driver, and rank results waiting for the monitor
  sample_item_t pending_samples[$];
  rank_result_t expected_ranks[$];

  // Shadow of the filter: window kept in arrival order and in ascending order
  sample_t   arrival_order[WINDOW_MAX];
  sample_t   ascending[WINDOW_MAX];
  int        win_fill;
  int        win_head;
  cfg_data_t len_setting;
  cfg_data_t pct_setting;

  // No idling on either side while this is set
  logic steady;

  int in_gap;
  int out_gap;
  int accepted_count;
  int results_seen;
  int mismatch_count;
  int directed_count;
  int random_count;
  int config_phases;

  always #5 clk = ~clk;

  // Admit one sample into the shadow window and return the rank it produces.
  function automatic rank_result_t admit_sample(sample_t value, logic restart);
    int           len;
    int           pct;
    int           pos;
    int           i;
    int           k;
    logic         found;
    rank_result_t res;
    len = (len_setting < 1) ? 1 : ((len_setting > WINDOW_MAX) ? WINDOW_MAX : len_setting);
    pct = (pct_setting > PERCENT_FULL) ? PERCENT_FULL : pct_setting;
    if (restart) begin
      win_fill = 0;
      win_head = 0;
    end
    // evict oldest until the new sample fits; covers a window shrunk while full
    while (win_fill >= len) begin
      pos   = win_fill - 1;
      found = 1'b0;
      for (i = 0; i < win_fill; i++) begin
        if (!found && ascending[i] == arrival_order[win_head]) begin
          pos   = i;
          found = 1'b1;
        end
      end
      for (i = pos; i + 1 < win_fill; i++) ascending[i] = ascending[i + 1];
      win_head = (win_head + 1) % WINDOW_MAX;
      win_fill--;
    end
    arrival_order[(win_head + win_fill) % WINDOW_MAX] = value;
    i = win_fill;
    while (i > 0 && ascending[i - 1] > value) begin
      ascending[i] = ascending[i - 1];
      i--;
    end
    ascending[i] = value;
    win_fill++;
    // k = ceil(pct*n/100), kept within 1..n
    k = (pct * win_fill + PERCENT_FULL - 1) / PERCENT_FULL;
    if (k < 1) k = 1;
    if (k > win_fill) k = win_fill;
    res.rank_value = ascending[k - 1];
    res.fill_count = fill_t'(win_fill);
    return res;
  endfunction

  // Register write; only called while the filter is idle.
  task automatic write_register(cfg_idx_t idx, cfg_data_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_WINDOW_LENGTH: len_setting = data;
      REG_PERCENT:       pct_setting = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(sample_t value, logic restart);
    sample_item_t item;
    item.sample     = value;
    item.start_req  = restart;
    pending_samples = {pending_samples, item};
  endtask

  // Sender holds off until every queued sample has gone and every result came back.
  // Checked on the falling edge so nothing is mid-update.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_ch.valid || expected_ranks.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Driver: presents queued samples, holds each until its transfer, and
  // predicts the result at the transfer edge. Gaps come in bursts of random
  // length so they land on every stage of the filter's per-sample sequence.
  always @(posedge clk) begin : drive_samples
    sample_item_t nxt;
    rank_result_t pred;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pred = admit_sample(in_ch.sample, in_ch.start_req);
        expected_ranks = {expected_ranks, pred};
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) in_gap--;
        else if (!steady && $urandom_range(99) < 5) in_gap = $urandom_range(16, 1);
        if (in_gap == 0 && pending_samples.size() != 0) begin
          nxt = pending_samples[0];
          pending_samples.delete(0);
          in_ch.valid     <= 1'b1;
          in_ch.sample    <= nxt.sample;
          in_ch.start_req <= nxt.start_req;
        end else begin
          // idle: junk payload with valid low must be ignored
          in_ch.valid     <= 1'b0;
          in_ch.sample    <= sample_t'($urandom());
          in_ch.start_req <= 1'($urandom());
        end
      end
    end
  end

  // Monitor: stalls ready at random and checks every result transfer
  // against the oldest prediction.
  always @(posedge clk) begin : check_ranks
    rank_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_ranks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result: value %0d fill %0d", $realtime,
                     out_ch.rank_value, out_ch.fill_count);
        end else begin
          want = expected_ranks[0];
          expected_ranks.delete(0);
          if (out_ch.rank_value !== want.rank_value ||
              out_ch.fill_count !== want.fill_count) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: result %0d: expected value %0d fill %0d, got value %0d fill %0d",
                       $realtime, results_seen, want.rank_value, want.fill_count,
                       out_ch.rank_value, out_ch.fill_count);
          end
        end
      end
      if (out_gap > 0) out_gap--;
      else if (!steady && $urandom_range(99) < 5) out_gap = $urandom_range(16, 1);
      out_ch.ready <= (out_gap == 0);
    end
  end

  initial begin : stimulus
    int        n;
    int        i;
    logic      steady_done;
    cfg_data_t wlen;
    cfg_data_t pct;
    sample_t   value;

    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_WINDOW_LENGTH;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample    = '0;
    in_ch.start_req = 1'b0;
    out_ch.ready    = 1'b0;
    steady          = 1'b0;
    steady_done     = 1'b0;
    win_fill        = 0;
    win_head        = 0;
    len_setting     = cfg_data_t'(WINDOW_MAX);
    pct_setting     = cfg_data_t'(50);
    accepted_count  = 0;
    results_seen    = 0;
    mismatch_count  = 0;
    directed_count  = 0;
    random_count    = 0;
    config_phases   = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: median of 64. Field extremes, duplicates, then a restart.
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh0000, 1'b0);
    queue_sample(-16'sd1,   1'b0);
    queue_sample(16'sd1,    1'b0);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(-16'sd5,   1'b1);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sd9,    1'b0);
    directed_count += 9;
    wait_drained();

    // Window length zero acts as one; percent zero picks the minimum
    write_register(REG_WINDOW_LENGTH, 7'd0);
    write_register(REG_PERCENT, 7'd0);
    config_phases++;
    queue_sample(16'sd100,  1'b0);
    queue_sample(-16'sd100, 1'b0);
    queue_sample(16'sh7FFF, 1'b1);
    directed_count += 3;
    wait_drained();

    // Both registers saturate from the top; unmapped indexes are ignored
    write_register(REG_WINDOW_LENGTH, 7'd127);
    write_register(REG_PERCENT, 7'd127);
    write_register(REG_UNMAPPED_LO, 7'd3);
    write_register(REG_UNMAPPED_HI, 7'd0);
    config_phases++;
    queue_sample(16'sd7,    1'b1);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sd7,    1'b0);
    directed_count += 4;
    wait_drained();

    // Fill a window of four, then shrink it to two while full
    write_register(REG_WINDOW_LENGTH, 7'd4);
    write_register(REG_PERCENT, 7'd50);
    config_phases++;
    queue_sample(16'sd40, 1'b1);
    queue_sample(16'sd10, 1'b0);
    queue_sample(16'sd30, 1'b0);
    queue_sample(16'sd20, 1'b0);
    queue_sample(16'sd10, 1'b0);
    queue_sample(16'sd50, 1'b0);
    directed_count += 6;
    wait_drained();
    write_register(REG_WINDOW_LENGTH, 7'd2);
    config_phases++;
    queue_sample(-16'sd3, 1'b0);
    directed_count += 1;
    wait_drained();

    // Random phases: fresh settings each time, the window carried across
    // phases so that growing and shrinking both happen on a filled window.
    while (random_count < RANDOM_TARGET) begin
      case ($urandom_range(7))
        0:       wlen = 7'd0;
        1:       wlen = 7'd1;
        2:       wlen = cfg_data_t'(WINDOW_MAX);
        3:       wlen = cfg_data_t'($urandom_range(127, WINDOW_MAX + 1));
        default: wlen = cfg_data_t'($urandom_range(WINDOW_MAX - 1, 2));
      endcase
      case ($urandom_range(6))
        0:       pct = 7'd0;
        1:       pct = cfg_data_t'(PERCENT_FULL);
        2:       pct = cfg_data_t'($urandom_range(127, PERCENT_FULL + 1));
        default: pct = cfg_data_t'($urandom_range(PERCENT_FULL - 1, 1));
      endcase
      write_register(REG_WINDOW_LENGTH, wlen);
      write_register(REG_PERCENT, pct);
      if ($urandom_range(3) == 0)
        write_register($urandom_range(1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                       cfg_data_t'($urandom()));
      config_phases++;

      // one long phase with both sides at full rate
      if (!steady_done && random_count >= 500) begin
        steady      = 1'b1;
        steady_done = 1'b1;
      end

      n = $urandom_range(180, 100);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(9))
          0:          value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          1, 2, 3:    value = sample_t'($urandom_range(15)) - 16'sd8;  // many repeats
          default:    value = sample_t'($urandom());
        endcase
        queue_sample(value, $urandom_range(99) < 3);
      end
      random_count += n;
      wait_drained();
      steady = 1'b0;
    end

    repeat (20) @(posedge clk);
    $display("summary: %0d samples accepted (%0d directed, %0d random), %0d results checked",
             accepted_count, directed_count, random_count, results_seen);
    $display("summary: %0d register settings, %0d mismatches", config_phases, mismatch_count);
    if (mismatch_count == 0 && expected_ranks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("watchdog expired: %0d samples accepted, %0d results pending",
             accepted_count, expected_ranks.size());
    $display("tb: failure");
    $finish;
  end

endmodule
